// File: rtl/core/itoa_pkg.sv
// shared types, constants and helpers for the integer to ascii radix unit
package itoa_pkg;

    localparam int DEF_VALUE_WIDTH = 32;
    localparam int RADIX_W         = 6;
    localparam int CHAR_W          = 8;
    localparam int DIV_STEPS       = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] DECIMAL   = 6'd10;

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
    localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;
    localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'h30;
    localparam logic [CHAR_W-1:0] ALPHA_BASE = 8'h57;

    typedef struct packed {
        logic bad_radix;
        logic minus;
    } itoa_class_t;

    localparam int CLASS_W = $bits(itoa_class_t);

    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [RADIX_W-1:0] digit);
        logic [CHAR_W-1:0] d;
        d = {{(CHAR_W-RADIX_W){1'b0}}, digit};
        if (digit < DECIMAL)
        begin
            return ZERO_CHAR + d;
        end
        return ALPHA_BASE + d;
    endfunction

endpackage

// File: rtl/core/itoa_front.sv
// front end: unpacks an input beat and classifies it into a queue entry
module itoa_front #(
    parameter int VALUE_WIDTH = itoa_pkg::DEF_VALUE_WIDTH,
    parameter int IN_W        = 40,
    parameter int ENTRY_W     = VALUE_WIDTH + itoa_pkg::RADIX_W + itoa_pkg::CLASS_W
) (
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [IN_W-1:0]    s_axis_tdata,
    input  logic               q_full,
    output logic               q_push,
    output logic [ENTRY_W-1:0] q_wdata
);

    logic [VALUE_WIDTH-1:0]       value;
    logic [itoa_pkg::RADIX_W-1:0] radix;
    logic [VALUE_WIDTH-1:0]       magnitude;
    itoa_pkg::itoa_class_t        cls;

    always_comb
    begin
        value         = s_axis_tdata[VALUE_WIDTH-1:0];
        radix         = s_axis_tdata[VALUE_WIDTH +: itoa_pkg::RADIX_W];
        magnitude     = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
        cls.bad_radix = (radix < itoa_pkg::RADIX_MIN) || (radix > itoa_pkg::RADIX_MAX);
        cls.minus     = value[VALUE_WIDTH-1] && (radix == itoa_pkg::DECIMAL);
        q_wdata       = {cls, radix, magnitude};
        s_axis_tready = !q_full;
        q_push        = s_axis_tvalid && !q_full;
    end

endmodule

// File: rtl/core/itoa_queue.sv
// two-entry queue between front end and digit engine
module itoa_queue #(
    parameter int DATA_W = 40
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    input  logic              pop,
    output logic [DATA_W-1:0] rdata,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W  = $clog2(itoa_pkg::QUEUE_DEPTH);
    localparam int FILL_W = $clog2(itoa_pkg::QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] entries_reg [itoa_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (fill_reg == FILL_W'(itoa_pkg::QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign rdata   = entries_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(itoa_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(itoa_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/itoa_back.sv
// digit engine: divides out digits, stacks them, emits characters msd first
module itoa_back #(
    parameter int VALUE_WIDTH = itoa_pkg::DEF_VALUE_WIDTH,
    parameter int ENTRY_W     = VALUE_WIDTH + itoa_pkg::RADIX_W + itoa_pkg::CLASS_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  logic [ENTRY_W-1:0]          q_rdata,
    output logic                        q_pop,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [itoa_pkg::CHAR_W-1:0] m_axis_tdata,
    output logic                        m_axis_tlast
);

    localparam int RW     = itoa_pkg::RADIX_W;
    localparam int STEPS  = itoa_pkg::DIV_STEPS;
    localparam int PASSES = (VALUE_WIDTH + STEPS - 1) / STEPS;
    localparam int WORK_W = PASSES * STEPS;
    localparam int PASS_W = $clog2(PASSES + 1);
    localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int AW     = $clog2(VALUE_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_READ,
        ST_HOLD,
        ST_TERM
    } state_t;

    state_t                     state_reg;
    logic [WORK_W-1:0]          work_reg;
    logic [WORK_W-1:0]          work_next;
    logic [RW-1:0]              rem_reg;
    logic [RW-1:0]              rem_next;
    logic [RW-1:0]              radix_reg;
    itoa_pkg::itoa_class_t      cls_reg;
    logic [PASS_W-1:0]          pass_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       out_valid_reg;
    logic [itoa_pkg::CHAR_W-1:0] out_char_reg;
    logic                       out_last_reg;
    logic [RW-1:0]              digit_mem [VALUE_WIDTH];
    logic [RW-1:0]              rd_data_reg;
    logic                       out_free;
    logic                       out_load;
    logic                       last_pass;
    logic                       mem_wr;
    logic                       mem_rd;
    logic [RW:0]                trial;

    itoa_pkg::itoa_class_t      q_cls;
    logic [RW-1:0]              q_radix;
    logic [VALUE_WIDTH-1:0]     q_mag;

    assign {q_cls, q_radix, q_mag} = q_rdata;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_load      = out_free && (((state_reg == ST_SIGN) && cls_reg.minus) ||
                                        (state_reg == ST_HOLD) || (state_reg == ST_TERM));
    assign last_pass     = (pass_reg == PASS_W'(PASSES - 1));
    assign q_pop         = (state_reg == ST_IDLE) && !q_empty;
    assign mem_wr        = (state_reg == ST_DIV) && last_pass;
    assign mem_rd        = (state_reg == ST_READ) && (count_reg != '0);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;

    // restoring division, several quotient bits per cycle
    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        trial     = '0;
        for (int i = 0; i < STEPS; i++)
        begin
            trial     = {rem_next, work_next[WORK_W-1]};
            work_next = {work_next[WORK_W-2:0], 1'b0};
            if (trial >= {1'b0, radix_reg})
            begin
                trial        = trial - {1'b0, radix_reg};
                work_next[0] = 1'b1;
            end
            rem_next = trial[RW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            digit_mem[count_reg[AW-1:0]] <= rem_next;
        end
        if (mem_rd)
        begin
            rd_data_reg <= digit_mem[AW'(count_reg - 1'b1)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
            work_reg      <= '0;
            rem_reg       <= '0;
            radix_reg     <= '0;
            cls_reg       <= '0;
            pass_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        work_reg  <= {{(WORK_W-VALUE_WIDTH){1'b0}}, q_mag};
                        rem_reg   <= '0;
                        radix_reg <= q_radix;
                        cls_reg   <= q_cls;
                        pass_reg  <= '0;
                        count_reg <= '0;
                        state_reg <= q_cls.bad_radix ? ST_TERM : ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    work_reg <= work_next;
                    if (last_pass)
                    begin
                        rem_reg   <= '0;
                        pass_reg  <= '0;
                        count_reg <= count_reg + 1'b1;
                        if (work_next == '0)
                        begin
                            state_reg <= ST_SIGN;
                        end
                    end
                    else
                    begin
                        rem_reg  <= rem_next;
                        pass_reg <= pass_reg + 1'b1;
                    end
                end
                ST_SIGN:
                begin
                    if (!cls_reg.minus)
                    begin
                        state_reg <= ST_READ;
                    end
                    else if (out_free)
                    begin
                        out_char_reg  <= itoa_pkg::MINUS_CHAR;
                        out_last_reg  <= 1'b0;
                        state_reg     <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    if (count_reg == '0)
                    begin
                        state_reg <= ST_TERM;
                    end
                    else
                    begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        out_char_reg  <= itoa_pkg::digit_glyph(rd_data_reg);
                        out_last_reg  <= 1'b0;
                        state_reg     <= ST_READ;
                    end
                end
                ST_TERM:
                begin
                    if (out_free)
                    begin
                        out_char_reg  <= itoa_pkg::NUL_CHAR;
                        out_last_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/integer_to_ascii_radix_unit.sv
// top level of the integer to ascii radix unit
// Converts a signed integer to its ASCII text in a base from 2 to 36.
// Input stream (s_axis): one beat per number, value in the low bits and the
// radix above it. Output stream (m_axis): one beat per character, most
// significant digit first, lower-case letters for digits 10 to 35, a leading
// '-' only for negative values in base 10, and a closing NUL beat with tlast.
// Any other radix yields only the NUL beat.
// The front end classifies each number into a two-entry queue, so up to two
// numbers are taken while the digit engine is still busy or stalled.
// Each digit is divided out by the shared divider, which retires 8 quotient
// bits per cycle; digits go to a small stack memory and are read back, last
// digit found first, while the previous character waits on the output.
// Reset empties the queue and drops any half-sent string.
// When m_axis_tready is low the current character holds and the engine waits
// to send; the input side keeps taking beats until the queue is full.
module integer_to_ascii_radix_unit #(
    parameter int VALUE_WIDTH = itoa_pkg::DEF_VALUE_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // value, radix
    input  logic [((VALUE_WIDTH + itoa_pkg::RADIX_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // character
    output logic [itoa_pkg::CHAR_W-1:0] m_axis_tdata,
    output logic                        m_axis_tlast
);

    localparam int IN_W    = ((VALUE_WIDTH + itoa_pkg::RADIX_W + 7) / 8) * 8;
    localparam int ENTRY_W = VALUE_WIDTH + itoa_pkg::RADIX_W + itoa_pkg::CLASS_W;

    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    logic [ENTRY_W-1:0] q_wdata;
    logic [ENTRY_W-1:0] q_rdata;

    itoa_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .IN_W        (IN_W),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    itoa_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    itoa_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_rdata       (q_rdata),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_last_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == itoa_pkg::NUL_CHAR)
        else $error("last beat is not nul");

    a_body_is_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            (m_axis_tdata == itoa_pkg::MINUS_CHAR) ||
            (m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39) ||
            (m_axis_tdata >= 8'h61 && m_axis_tdata <= 8'h7A))
        else $error("body beat is not a digit or sign");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full && !q_pop |=> q_full)
        else $error("queue entry lost while full");

endmodule
